@@ rtl/ukl_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ukl_pkg: shared types and constants of the UTF-8 keyword lexer
// Request structs, token kinds and the keyword ROM.
// ----------------------------------------------------------------------------
package ukl_pkg;

  localparam int OffW  = 24;
  localparam int LineW = 16;
  localparam int RomWords = 15;
  localparam int RomChars = 11;

  localparam logic [5:0] K_IDENT   = 6'd15;
  localparam logic [5:0] K_INT     = 6'd16;
  localparam logic [5:0] K_DEC     = 6'd17;
  localparam logic [5:0] K_UNKNOWN = 6'd39;
  localparam logic [5:0] K_EOF     = 6'd40;

  typedef struct packed {
    logic [7:0] source_byte;
    logic       byte_present;
    logic       end_of_source;
  } in_req_t;

  typedef struct packed {
    logic [5:0]       token_kind;
    logic [OffW-1:0]  start_offset;
    logic [OffW-1:0]  token_length;
    logic [LineW-1:0] line_number;
    logic             last_of_run;
  } out_req_t;

  // Up to four tokens produced by one source byte.
  typedef struct packed {
    logic [2:0]   count;
    out_req_t [3:0] tok;
  } burst_t;

  function automatic logic [5:0] single_kind(input logic [7:0] b);
    unique case (b)
      8'h2B: single_kind = 6'd18;
      8'h2D: single_kind = 6'd19;
      8'h2A: single_kind = 6'd20;
      8'h2F: single_kind = 6'd21;
      8'h25: single_kind = 6'd22;
      8'h3D: single_kind = 6'd23;
      8'h3E: single_kind = 6'd25;
      8'h3C: single_kind = 6'd27;
      8'h21: single_kind = 6'd29;
      8'h28: single_kind = 6'd31;
      8'h29: single_kind = 6'd32;
      8'h7B: single_kind = 6'd33;
      8'h7D: single_kind = 6'd34;
      8'h5B: single_kind = 6'd35;
      8'h5D: single_kind = 6'd36;
      8'h3B: single_kind = 6'd37;
      8'h2C: single_kind = 6'd38;
      default: single_kind = K_UNKNOWN;
    endcase
  endfunction

  function automatic logic [3:0] kw_chars(input int k);
    unique case (k)
      0: kw_chars = 4'd6;   1: kw_chars = 4'd5;   2: kw_chars = 4'd4;
      3: kw_chars = 4'd6;   4: kw_chars = 4'd10;  5: kw_chars = 4'd6;
      6: kw_chars = 4'd11;  7: kw_chars = 4'd7;   8: kw_chars = 4'd5;
      9: kw_chars = 4'd3;   10: kw_chars = 4'd5;  11: kw_chars = 4'd6;
      12: kw_chars = 4'd5;  13: kw_chars = 4'd4;  14: kw_chars = 4'd6;
      default: kw_chars = 4'd0;
    endcase
  endfunction

  function automatic logic [7:0] kw_char(input int k, input int c);
    logic [7:0] r [RomWords][RomChars];
    r = '{
      '{8'h38,8'h02,8'h16,8'h4D,8'h2F,8'h3E,8'h00,8'h00,8'h00,8'h00,8'h00},
      '{8'h26,8'h36,8'h2E,8'h3F,8'h15,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
      '{8'h32,8'h47,8'h16,8'h3E,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
      '{8'h1A,8'h30,8'h3F,8'h24,8'h4D,8'h30,8'h00,8'h00,8'h00,8'h00,8'h00},
      '{8'h38,8'h24,8'h4D,8'h2F,8'h2E,8'h3F,8'h25,8'h4D,8'h2F,8'h3E,8'h00},
      '{8'h24,8'h3E,8'h32,8'h3F,8'h15,8'h3E,8'h00,8'h00,8'h00,8'h00,8'h00},
      '{8'h26,8'h40,8'h30,8'h4D,8'h18,8'h38,8'h02,8'h16,8'h4D,8'h2F,8'h3E},
      '{8'h27,8'h28,8'h3E,8'h24,8'h4D,8'h2E,8'h15,8'h00,8'h00,8'h00,8'h00},
      '{8'h36,8'h42,8'h28,8'h4D,8'h2F,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
      '{8'h2F,8'h26,8'h3F,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
      '{8'h28,8'h3E,8'h39,8'h32,8'h47,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
      '{8'h2F,8'h24,8'h15,8'h4D,8'h37,8'h23,8'h00,8'h00,8'h00,8'h00,8'h00},
      '{8'h26,8'h47,8'h16,8'h3E,8'h13,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
      '{8'h38,8'h24,8'h4D,8'h2F,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
      '{8'h2E,8'h3F,8'h25,8'h4D,8'h2F,8'h3E,8'h00,8'h00,8'h00,8'h00,8'h00}
    };
    kw_char = r[k][c];
  endfunction

  // Expected byte of keyword k at byte position pos; valid=0 past its end.
  // pos * 43 >> 7 gives pos / 3 for every 6-bit pos.
  function automatic logic [8:0] rom_byte(input int k, input logic [5:0] pos);
    logic [12:0] prod;
    logic [5:0] ci;
    logic [5:0] rem;
    logic [7:0] off;
    prod = {7'd0, pos} * 13'd43;
    ci = prod[12:7];
    rem = pos - {ci[4:0], 1'b0} - ci;
    rom_byte = 9'd0;
    if (k < RomWords && ci < 6'(kw_chars(k))) begin
      off = kw_char(k, int'(ci));
      unique case (rem[1:0])
        2'd0: rom_byte = {1'b1, 8'hE0};
        2'd1: rom_byte = {1'b1, 8'hA6 + {6'd0, off[7:6]}};
        default: rom_byte = {1'b1, 2'b10, off[5:0]};
      endcase
    end
  endfunction

endpackage
`default_nettype wire

@@ rtl/utf8_keyword_lexer_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_keyword_lexer_unit: streaming UTF-8 keyword lexer
// Scanner front end and token queue back end.
// ----------------------------------------------------------------------------
// One byte is accepted per cycle while not stalled; its tokens (up to four)
// are registered, then written into a 16-entry queue and leave one per cycle
// while out_stall is low. The input stalls only when the queue has fewer than
// eight free entries (four may be in flight), so long bursts throttle input.
module utf8_keyword_lexer_unit #(
  parameter int KEYWORD_COUNT = 15,
  parameter int KEYWORD_MAX_BYTES = 33
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire ukl_pkg::in_req_t  in_data,
  input  wire logic              in_valid,
  output      logic              in_stall,
  output      ukl_pkg::out_req_t out_data,
  output      logic              out_valid,
  input  wire logic              out_stall
);
  import ukl_pkg::*;

  burst_t     burst;
  logic       burst_valid, take;
  logic [4:0] free;

  assign in_stall = free < 5'd8;
  assign take = in_valid && !in_stall;

  ukl_front #(
    .KEYWORD_COUNT(KEYWORD_COUNT), .KEYWORD_MAX_BYTES(KEYWORD_MAX_BYTES)
  ) u_front (
    .clk, .rst, .req(in_data), .take, .burst, .burst_valid
  );

  ukl_back u_back (
    .clk, .rst, .burst, .burst_valid, .free,
    .token(out_data), .valid(out_valid), .stall(out_stall)
  );

endmodule
`default_nettype wire

@@ rtl/ukl_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ukl_front: scanner of the keyword lexer
// Classifies one taken byte per cycle and writes the token burst it causes.
// ----------------------------------------------------------------------------
module ukl_front #(
  parameter int KEYWORD_COUNT = 15,
  parameter int KEYWORD_MAX_BYTES = 33
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire ukl_pkg::in_req_t req,
  input  wire logic            take,
  output      ukl_pkg::burst_t burst,
  output      logic            burst_valid
);
  import ukl_pkg::*;

  localparam logic [5:0] WordCap =
    6'(KEYWORD_MAX_BYTES < 63 ? KEYWORD_MAX_BYTES + 1 : 63);

  typedef enum logic [2:0] {
    M_IDLE, M_OPER, M_INT, M_DOT, M_FRAC, M_WORD
  } mode_t;

  mode_t                   mode;
  logic [7:0]              pend;
  logic [1:0]              skip;
  logic [OffW-1:0]         tstart, boff;
  logic [LineW-1:0]        lines;
  logic [KEYWORD_COUNT-1:0] cand;
  logic [5:0]              wbytes;

  mode_t                   mode_next;
  logic [7:0]              pend_next;
  logic [1:0]              skip_next;
  logic [OffW-1:0]         tstart_next, boff_next;
  logic [LineW-1:0]        lines_next;
  logic [KEYWORD_COUNT-1:0] cand_next;
  logic [5:0]              wbytes_next;
  burst_t                  b_next;

  function automatic logic is_digit(input logic [7:0] b);
    is_digit = b >= 8'h30 && b <= 8'h39;
  endfunction
  function automatic logic is_lead(input logic [7:0] b);
    is_lead = b[7:4] == 4'hE;
  endfunction
  function automatic logic is_word(input logic [7:0] b);
    is_word = (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) ||
              is_digit(b) || b == 8'h5F;
  endfunction

  always_comb begin
    logic [7:0] b;
    logic       restart, lead, lf_inc;
    logic [2:0] byte_cnt;
    logic [5:0] kk;
    logic [OffW-1:0] dot;
    mode_next = mode; pend_next = pend; skip_next = skip;
    tstart_next = tstart; boff_next = boff; lines_next = lines;
    cand_next = cand; wbytes_next = wbytes;
    b_next = '0;
    b = req.source_byte;
    restart = 1'b0;
    lead = 1'b0;
    kk = K_IDENT;
    for (int k = KEYWORD_COUNT - 1; k >= 0; k--) begin
      if (k < RomWords && cand[k] &&
          {1'b0, kw_chars(k), 1'b0} + {2'b0, kw_chars(k)} == wbytes)
        kk = 6'(k);
    end
    dot = boff - OffW'(1);
    if (req.byte_present) begin
      unique case (mode)
        M_OPER: begin
          if (b == 8'h3D) begin
            b_next.tok[0].token_kind = single_kind(pend) + 6'd1;
            b_next.tok[0].token_length = 24'(2);
            b_next.count = 3'd1;
            mode_next = M_IDLE;
          end else begin
            b_next.tok[0].token_kind = single_kind(pend);
            b_next.tok[0].token_length = 24'(1);
            b_next.count = 3'd1;
            restart = 1'b1;
          end
          b_next.tok[0].start_offset = 24'(tstart);
        end
        M_INT: begin
          if (b == 8'h2E) mode_next = M_DOT;
          else if (!is_digit(b)) begin
            b_next.tok[0] = '{K_INT, 24'(tstart), 24'(boff - tstart), '0, 1'b0};
            b_next.count = 3'd1;
            restart = 1'b1;
          end
        end
        M_DOT: begin
          if (is_digit(b)) mode_next = M_FRAC;
          else begin
            b_next.tok[0] = '{K_INT, 24'(tstart), 24'(dot - tstart), '0, 1'b0};
            b_next.tok[1] = '{K_UNKNOWN, 24'(dot), 24'(1), '0, 1'b0};
            b_next.count = 3'd2;
            restart = 1'b1;
          end
        end
        M_FRAC: begin
          if (!is_digit(b)) begin
            b_next.tok[0] = '{K_DEC, 24'(tstart), 24'(boff - tstart), '0, 1'b0};
            b_next.count = 3'd1;
            restart = 1'b1;
          end
        end
        M_WORD: begin
          if (skip != 2'd0 || is_word(b) || is_lead(b)) begin
            for (int k = 0; k < KEYWORD_COUNT; k++)
              if (rom_byte(k, wbytes) != {1'b1, b}) cand_next[k] = 1'b0;
            if (wbytes < WordCap) wbytes_next = wbytes + 6'd1;
            if (skip != 2'd0) skip_next = skip - 2'd1;
            else if (is_lead(b)) skip_next = 2'd2;
          end else begin
            b_next.tok[0] = '{kk, 24'(tstart), 24'(boff - tstart), '0, 1'b0};
            b_next.count = 3'd1;
            restart = 1'b1;
          end
        end
        default: restart = 1'b1;
      endcase
      if (restart) begin
        tstart_next = boff;
        mode_next = M_IDLE;
        lead = is_lead(b);
        if (b == 8'h3D || b == 8'h3E || b == 8'h3C || b == 8'h21) begin
          mode_next = M_OPER;
          pend_next = b;
        end else if (b == 8'h20 || b == 8'h0D || b == 8'h09) begin
          mode_next = M_IDLE;
        end else if (b == 8'h0A) begin
          if (lines != '1) lines_next = lines + LineW'(1);
        end else if (is_digit(b)) begin
          mode_next = M_INT;
        end else if (is_word(b) || lead) begin
          mode_next = M_WORD;
          skip_next = lead ? 2'd2 : 2'd0;
          wbytes_next = (WordCap > 6'd0) ? 6'd1 : 6'd0;
          for (int k = 0; k < KEYWORD_COUNT; k++)
            cand_next[k] = rom_byte(k, 6'd0) == {1'b1, b};
        end else begin
          b_next.tok[b_next.count[1:0]] =
            '{single_kind(b), 24'(boff), 24'(1), '0, 1'b0};
          b_next.count = b_next.count + 3'd1;
        end
      end
      boff_next = boff + OffW'(1);
    end
    byte_cnt = b_next.count;
    lf_inc = req.byte_present && restart && b == 8'h0A;
    if (req.end_of_source) begin
      unique case (mode_next)
        M_OPER: begin
          b_next.tok[b_next.count[1:0]] =
            '{single_kind(pend_next), 24'(tstart_next), 24'(1), '0, 1'b0};
          b_next.count = b_next.count + 3'd1;
        end
        M_INT, M_FRAC: begin
          b_next.tok[b_next.count[1:0]] =
            '{(mode_next == M_INT) ? K_INT : K_DEC, 24'(tstart_next),
              24'(boff_next - tstart_next), '0, 1'b0};
          b_next.count = b_next.count + 3'd1;
        end
        M_DOT: begin
          b_next.tok[b_next.count[1:0]] = '{K_INT, 24'(tstart_next),
            24'(boff_next - OffW'(1) - tstart_next), '0, 1'b0};
          b_next.tok[b_next.count[1:0] + 2'd1] =
            '{K_UNKNOWN, 24'(boff_next - OffW'(1)), 24'(1), '0, 1'b0};
          b_next.count = b_next.count + 3'd2;
        end
        M_WORD: begin
          kk = K_IDENT;
          for (int k = KEYWORD_COUNT - 1; k >= 0; k--) begin
            if (k < RomWords && cand_next[k] &&
                {1'b0, kw_chars(k), 1'b0} + {2'b0, kw_chars(k)} == wbytes_next)
              kk = 6'(k);
          end
          b_next.tok[b_next.count[1:0]] =
            '{kk, 24'(tstart_next), 24'(boff_next - tstart_next), '0, 1'b0};
          b_next.count = b_next.count + 3'd1;
        end
        default: ;
      endcase
      b_next.tok[b_next.count[1:0]] = '{K_EOF, 24'(boff_next), 24'(0), '0, 1'b0};
      b_next.count = b_next.count + 3'd1;
      mode_next = M_IDLE; pend_next = '0; skip_next = '0;
      tstart_next = '0; boff_next = '0;
      cand_next = '1; wbytes_next = '0;
    end
    for (int i = 0; i < 4; i++) begin
      b_next.tok[i].line_number = (lf_inc && 3'(i) < byte_cnt) ? lines : lines_next;
      b_next.tok[i].last_of_run = (3'(i) + 3'd1 == b_next.count);
    end
    if (req.end_of_source) lines_next = LineW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE; pend <= '0; skip <= '0; tstart <= '0; boff <= '0;
      lines <= LineW'(1); cand <= '1; wbytes <= '0; burst_valid <= 1'b0;
    end else begin
      burst_valid <= 1'b0;
      if (take) begin
        mode <= mode_next; pend <= pend_next; skip <= skip_next;
        tstart <= tstart_next; boff <= boff_next; lines <= lines_next;
        cand <= cand_next; wbytes <= wbytes_next;
        burst_valid <= b_next.count != 3'd0;
      end
    end
    if (take) burst <= b_next;
  end

endmodule
`default_nettype wire

@@ rtl/ukl_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ukl_back: token queue of the keyword lexer
// Holds token requests and delivers them one at a time.
// ----------------------------------------------------------------------------
module ukl_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire ukl_pkg::burst_t  burst,
  input  wire logic             burst_valid,
  output      logic [4:0]       free,
  output      ukl_pkg::out_req_t token,
  output      logic             valid,
  input  wire logic             stall
);
  import ukl_pkg::*;

  out_req_t   mem [16];
  logic [3:0] wp, rp;
  logic [4:0] cnt;
  logic       pop;

  assign valid = cnt != 5'd0;
  assign token = mem[rp];
  assign pop   = valid && !stall;
  assign free  = 5'd16 - cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (burst_valid) wp <= wp + 4'(burst.count);
      if (pop) rp <= rp + 4'd1;
      cnt <= cnt + (burst_valid ? 5'(burst.count) : 5'd0) - (pop ? 5'd1 : 5'd0);
    end
    if (burst_valid) begin
      for (int i = 0; i < 4; i++)
        if (3'(i) < burst.count) mem[wp + 4'(i)] <= burst.tok[i];
    end
  end

endmodule
`default_nettype wire
